[hdl/lcd_text_line_command_gen_defines.svh]
// Assertion macros shared by the checker of the text line command generator.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef LCD_TEXT_LINE_COMMAND_GEN_DEFINES_SVH
`define LCD_TEXT_LINE_COMMAND_GEN_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is held.
`define LTLCG_ASSERT_IMP(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (b)) else $error("lcd text line command check failed");

// Next-cycle implication, sampled on the rising edge, off while reset is held.
`define LTLCG_ASSERT_NXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (b)) else $error("lcd text line command check failed");

`endif

[hdl/ltlcg_pkg.sv]
package ltlcg_pkg;

  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_CHAR   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [7:0] CMD_FUNC_SET = 8'h30;
  localparam logic [7:0] PAD_CHAR     = 8'h20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_results;
    logic last_step;
  } dp_sts_t;

  // DDRAM base address of each display row.
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0: b = 8'h80;
      2'd1: b = 8'h90;
      2'd2: b = 8'h88;
      2'd3: b = 8'h98;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

endpackage

[hdl/ltlcg_ctrl.sv]
module ltlcg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ltlcg_pkg::dp_sts_t sts,
  output ltlcg_pkg::ctl_cmd_t cmd
);
  import ltlcg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign cmd.load = accept;
  assign cmd.emit = (state_r == ST_RUN) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.has_results) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.emit && sts.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/ltlcg_datapath.sv]
module ltlcg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ltlcg_pkg::in_item_t  in_item,
  input  ltlcg_pkg::ctl_cmd_t  cmd,
  output ltlcg_pkg::dp_sts_t   sts,
  output ltlcg_pkg::out_item_t out_item
);
  import ltlcg_pkg::*;

  // Display position, updated as each request is taken.
  logic [1:0] cur_row_r, cur_row_nxt;
  logic [3:0] char_count_r, char_count_nxt;

  // Details of the request being played out.
  logic [1:0] func_r;
  logic [7:0] ch_r;
  logic [7:0] addr_r, addr_nxt;
  logic [3:0] num_r, num_nxt;
  logic [3:0] step_r;
  out_item_t  out_item_r, out_item_nxt;

  logic [3:0] cnt_inc;
  logic [1:0] row_inc;

  assign cnt_inc = char_count_r + 4'd1;
  assign row_inc = cur_row_r + 2'd1;

  always_comb begin
    cur_row_nxt    = cur_row_r;
    char_count_nxt = char_count_r;
    addr_nxt       = row_base(row_inc);
    num_nxt        = 4'd0;
    case (in_item.func)
      FUNC_BEGIN: begin
        num_nxt        = 4'd2;
        cur_row_nxt    = in_item.row[1:0];
        char_count_nxt = 4'd0;
        if (in_item.row[7:2] == 6'd0) begin
          addr_nxt = in_item.col + row_base(in_item.row[1:0]);
        end else begin
          addr_nxt = in_item.col;
        end
      end
      FUNC_CHAR: begin
        char_count_nxt = cnt_inc;
        if (cnt_inc == 4'd0) begin
          num_nxt     = 4'd3;
          cur_row_nxt = row_inc;
        end else begin
          num_nxt = 4'd1;
        end
      end
      FUNC_FINISH: begin
        // Spaces up to the end of the sixteen-character line.
        num_nxt        = 4'd0 - char_count_r;
        char_count_nxt = 4'd0;
      end
      default: begin
        num_nxt = 4'd0;
      end
    endcase
  end

  always_comb begin
    out_item_nxt.last = (step_r == num_r - 4'd1);
    case (func_r)
      FUNC_BEGIN: begin
        out_item_nxt.is_data = 1'b0;
        out_item_nxt.value   = (step_r == 4'd0) ? CMD_FUNC_SET : addr_r;
      end
      FUNC_CHAR: begin
        if (step_r == 4'd0) begin
          out_item_nxt.is_data = 1'b1;
          out_item_nxt.value   = ch_r;
        end else begin
          out_item_nxt.is_data = 1'b0;
          out_item_nxt.value   = (step_r == 4'd1) ? CMD_FUNC_SET : addr_r;
        end
      end
      default: begin
        out_item_nxt.is_data = 1'b1;
        out_item_nxt.value   = PAD_CHAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= 2'd0;
      char_count_r <= 4'd0;
      step_r       <= 4'd0;
    end else if (cmd.load) begin
      cur_row_r    <= cur_row_nxt;
      char_count_r <= char_count_nxt;
      step_r       <= 4'd0;
    end else if (cmd.emit) begin
      step_r <= step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_item.func;
      ch_r   <= in_item.ch;
      addr_r <= addr_nxt;
      num_r  <= num_nxt;
    end
    if (cmd.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign sts.has_results = (num_nxt != 4'd0);
  assign sts.last_step   = out_item_nxt.last;
  assign out_item        = out_item_r;

endmodule

[hdl/lcd_text_line_command_gen.sv]
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_item   (func, row, col, ch)
// out_     output     out_valid / out_ready  out_item  (is_data, value, last)
//
// A request is taken while in_ready is high, then plays out its results at one per
// cycle into the output register unless a waiting result is held off by out_ready.
// in_ready stays low until the final result has moved into the register (0 to 15
// results; a pad of fifteen spaces is the longest). A request with no results leaves
// in_ready high. The output register lets the next request be taken while the final
// result still waits. Reset is synchronous and active low.
module lcd_text_line_command_gen (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ltlcg_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ltlcg_pkg::out_item_t out_item
);
  import ltlcg_pkg::*;

  // The controller decides when a request is taken and when a result moves into
  // the output register; the datapath holds the display position and builds bytes.
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ltlcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Begin sends function set and the start address; a character sends a data write
  // and, on completing a sixteen-character line, function set and the next row
  // base; finish pads the current line with spaces.
  ltlcg_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

[hdl/ltlcg_checker.sv]
`include "lcd_text_line_command_gen_defines.svh"

module ltlcg_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input ltlcg_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input ltlcg_pkg::out_item_t out_item
);
  import ltlcg_pkg::*;

  // A stalled result stays put.
  `LTLCG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // An unused function code produces nothing, so the block stays ready.
  `LTLCG_ASSERT_NXT(a_none_ready, in_valid && in_ready && in_item.func == FUNC_NONE, in_ready)

  // A begin always produces results, so the block is busy afterwards.
  `LTLCG_ASSERT_NXT(a_begin_busy, in_valid && in_ready && in_item.func == FUNC_BEGIN, !in_ready)

  // The block only becomes busy by taking a request.
  `LTLCG_ASSERT_IMP(a_busy_cause, !in_ready, $past(in_valid && in_ready) || !$past(in_ready))

endmodule

bind lcd_text_line_command_gen ltlcg_checker u_ltlcg_checker (.*);

[bench/lcd_text_line_command_gen_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the text line command generator. Requests go in on
// one valid/ready channel and the resulting bus writes come out on another.
// Every accepted request is fed through a predictor that keeps its own copy of
// the display row and the character count, and the bus writes it predicts wait
// in a queue until the block produces them.
module lcd_text_line_command_gen_tb;

  import ltlcg_pkg::*;

  // Long enough for the slowest legal run: some 550 requests, each able to
  // cause fifteen writes behind a receiver that stalls four times in five,
  // plus the deliberate hold-offs. That is several times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Idling percentages, changed between phases by the test sequence.
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  // A hold-off is requested by the test sequence and then counted down by
  // the receiver process itself.
  int hold_off_request = 0;
  int hold_off_left = 0;

  int cycle_count = 0;
  int mismatches = 0;
  int requests_sent = 0;

  // The predictor's own copy of the block's state.
  logic [1:0] disp_row = 2'd0;
  logic [3:0] line_chars = 4'd0;

  // Bus writes predicted but not yet seen on the output.
  out_item_t pending_writes[$];

  lcd_text_line_command_gen i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Guard against a hung block: the run is ended as a failure at the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // DDRAM base address of each of the four display rows.
  function automatic logic [7:0] line_start_addr(input logic [1:0] r);
    logic [7:0] a;
    case (r)
      2'd0: a = 8'h80;
      2'd1: a = 8'h90;
      2'd2: a = 8'h88;
      default: a = 8'h98;
    endcase
    return a;
  endfunction

  // Works out the bus writes that one accepted request causes and queues
  // them, the final one marked as last. The state is updated alongside.
  function automatic void predict_bus_writes(input in_item_t req);
    out_item_t writes[16];
    int        n;
    logic [7:0] addr;
    int        k;
    n = 0;
    case (req.func)
      FUNC_BEGIN: begin
        // A row above three leaves the column byte as it is; otherwise the
        // row base is added and the sum wraps at eight bits.
        addr = (req.row <= 8'd3) ? req.col + line_start_addr(req.row[1:0]) : req.col;
        writes[n] = '{is_data: 1'b0, value: CMD_FUNC_SET, last: 1'b0};
        n++;
        writes[n] = '{is_data: 1'b0, value: addr, last: 1'b0};
        n++;
        disp_row = req.row[1:0];
        line_chars = 4'd0;
      end
      FUNC_CHAR: begin
        writes[n] = '{is_data: 1'b1, value: req.ch, last: 1'b0};
        n++;
        line_chars = line_chars + 4'd1;
        // The sixteenth character of a line moves on to the next row.
        if (line_chars == 4'd0) begin
          disp_row = disp_row + 2'd1;
          writes[n] = '{is_data: 1'b0, value: CMD_FUNC_SET, last: 1'b0};
          n++;
          writes[n] = '{is_data: 1'b0, value: line_start_addr(disp_row), last: 1'b0};
          n++;
        end
      end
      FUNC_FINISH: begin
        // Pad the rest of the line with spaces; nothing on a line boundary.
        if (line_chars != 4'd0) begin
          for (k = int'(line_chars); k < 16; k++) begin
            writes[n] = '{is_data: 1'b1, value: PAD_CHAR, last: 1'b0};
            n++;
          end
        end
        line_chars = 4'd0;
      end
      default: begin
        // The unused code is ignored altogether.
      end
    endcase
    if (n > 0) begin
      writes[n - 1].last = 1'b1;
    end
    for (k = 0; k < n; k++) begin
      pending_writes.push_back(writes[k]);
    end
  endfunction

  function automatic in_item_t make_request(input logic [1:0] f, input logic [7:0] r,
                                            input logic [7:0] c, input logic [7:0] character);
    in_item_t req;
    req.func = f;
    req.row = r;
    req.col = c;
    req.ch = character;
    return req;
  endfunction

  // Offers one request and waits for it to be taken. The valid is lowered
  // only when the sender chooses to idle first, so that back-to-back requests
  // keep it high without a second assignment in the same time step.
  task automatic send_request(input in_item_t req);
    bit idled;
    idled = 1'b0;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      idled = 1'b1;
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < sender_idle_pct) @(posedge clk);
    end
    if (idled || !in_valid) begin
      in_valid <= 1'b1;
    end
    in_item <= req;
    // The ready seen just after the edge is the value the edge sampled.
    do @(posedge clk); while (!in_ready);
    predict_bus_writes(req);
    if (req.func != FUNC_NONE) begin
      requests_sent++;
    end
  endtask

  // The receiver: stalls at random, or for a whole hold-off when one has
  // been asked for, the length being counted here.
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Each accepted bus write is compared with the oldest one predicted.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected bus write: is_data %0b value %02h last %0b",
               out_item.is_data, out_item.value, out_item.last);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (out_item.is_data !== want.is_data) begin
          $error("is_data: expected %0b, got %0b", want.is_data, out_item.is_data);
          mismatches++;
        end
        if (out_item.value !== want.value) begin
          $error("value: expected %02h, got %02h", want.value, out_item.value);
          mismatches++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_item.last);
          mismatches++;
        end
      end
    end
  end

  // Characters straight after reset use row 0; a zero code and an all-ones
  // code go out as ordinary data bytes.
  task automatic test_chars_before_begin();
    send_request(make_request(FUNC_CHAR, 8'h00, 8'h00, 8'h00));
    send_request(make_request(FUNC_CHAR, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Every mapped row, the address wrapping past 0xFF, and rows above three
  // that send the column byte unchanged.
  task automatic test_begin_rows();
    send_request(make_request(FUNC_BEGIN, 8'd0, 8'h00, 8'h00));
    send_request(make_request(FUNC_BEGIN, 8'd1, 8'h7F, 8'h5A));
    send_request(make_request(FUNC_BEGIN, 8'd2, 8'h55, 8'hA5));
    send_request(make_request(FUNC_BEGIN, 8'd3, 8'hFF, 8'h00));
    send_request(make_request(FUNC_BEGIN, 8'd4, 8'h12, 8'h00));
    send_request(make_request(FUNC_BEGIN, 8'hFF, 8'hAA, 8'hFF));
  endtask

  // The previous begin left row 3 (from 255 taken modulo four), so a full
  // line of sixteen characters wraps the row round to 0. A finish right on
  // the line boundary then writes nothing.
  task automatic test_line_wrap();
    int i;
    for (i = 0; i < 16; i++) begin
      send_request(make_request(FUNC_CHAR, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'h41 + 8'(i)));
    end
    send_request(make_request(FUNC_FINISH, 8'h00, 8'h00, 8'h00));
  endtask

  // One character then a finish gives the longest pad, fifteen spaces.
  task automatic test_longest_pad();
    send_request(make_request(FUNC_CHAR, 8'h00, 8'h00, 8'h7E));
    send_request(make_request(FUNC_FINISH, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // The unused code must neither write anything nor disturb the state.
  task automatic test_unused_func();
    send_request(make_request(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_request(FUNC_CHAR, 8'h00, 8'h00, 8'h31));
  endtask

  // The receiver holds off for a long stretch while a begin, thirty characters and a
  // finish are offered, so the block fills up and has to stall its input.
  task automatic test_output_hold_off();
    int i;
    hold_off_request = 300;
    send_request(make_request(FUNC_BEGIN, 8'd2, 8'h03, 8'h00));
    for (i = 0; i < 30; i++) begin
      send_request(make_request(FUNC_CHAR, 8'h00, 8'h00, 8'($urandom_range(0, 255))));
    end
    send_request(make_request(FUNC_FINISH, 8'h00, 8'h00, 8'h00));
  endtask

  // Mostly well-formed lines (begin, characters, usually a finish) with
  // random content; the rest is stray requests of any code, which also
  // breaks lines up in odd places.
  task automatic test_random_lines(input int count);
    int goal;
    int nchars;
    int i;
    logic [7:0] r;
    logic [7:0] c;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        r = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 3));
        c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 15));
        send_request(make_request(FUNC_BEGIN, r, c, 8'($urandom_range(0, 255))));
        nchars = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 20);
        for (i = 0; i < nchars; i++) begin
          send_request(make_request(FUNC_CHAR, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end
        if ($urandom_range(0, 9) != 0) begin
          send_request(make_request(FUNC_FINISH, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end
      end else begin
        send_request(make_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: sender idles a little, receiver a great deal.
    sender_idle_pct = 22;
    receiver_idle_pct = 80;
    test_chars_before_begin();
    test_begin_rows();
    test_line_wrap();
    test_longest_pad();
    test_unused_func();
    test_random_lines(170);

    // Second phase: the other way round.
    sender_idle_pct = 80;
    receiver_idle_pct = 22;
    test_random_lines(170);

    // Last phase: no idling on either side, plus the long hold-off.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_output_hold_off();
    test_random_lines(160);

    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    // Run on for DRAIN_CYCLES to catch any write the block should not have made.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
